[design/rcl_random_agent_assign_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef RCL_RANDOM_AGENT_ASSIGN_CORE_DEFINES_SVH
`define RCL_RANDOM_AGENT_ASSIGN_CORE_DEFINES_SVH

// Same-cycle implication.
`define RCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rcl_raa_pkg.sv]
package rcl_raa_pkg;

  localparam int unsigned MAX_AGENTS_DEF  = 16;
  localparam int unsigned MAX_TASKS_DEF   = 256;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned AGENT_W     = 4;
  localparam int unsigned TASK_W      = 8;
  localparam int unsigned LOAD_W      = 16;
  localparam int unsigned DRAW_W      = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CAP_OUT_W   = 16;
  localparam int unsigned THR_OUT_W   = 16;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned GAMMA_W     = 9;
  localparam int unsigned AGENTS_W    = 5;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 9;

  // gamma is Q1.8: product is scaled down by 2^8 with round-up
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned ROUND_ADD = 255;

  localparam logic [AGENTS_W-1:0] AGENTS_RESET = 5'd16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_WEIGHT = 2'd0,
    OP_WRITE_CAP    = 2'd1,
    OP_ASSIGN       = 2'd2,
    OP_NOP          = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITE_OK = 2'd0,
    ST_ASSIGNED = 2'd1,
    ST_NO_AGENT = 2'd2
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAMMA  = 2'd0,
    CFG_AGENTS = 2'd1
  } cfg_idx_e;

endpackage

[design/rcl_raa_ram.sv]
module rcl_raa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/rcl_raa_mod.sv]
module rcl_raa_mod #(
  parameter int unsigned DIVIDEND_W = 16,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  run_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] num_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    rem_d;

  // restoring remainder, one dividend bit per cycle, MSB first
  always_comb begin
    trial = {rem_q, num_q[DIVIDEND_W-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
    end else begin
      rem_d = trial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DIVIDEND_W);
        num_q <= dividend_i;
        den_q <= divisor_i;
        rem_q <= '0;
      end else if (run_q) begin
        rem_q <= rem_d[DIVISOR_W-1:0];
        num_q <= num_q << 1;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[design/rcl_random_agent_assign_core.sv]
// Random agent assignment from a restricted candidate list.
// Item channel: an item is taken on a rising edge with start high and busy low.
//   Opcodes: write weight (agent, task), write agent capacity, assign task, no-op.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 gamma_q8,
//   1 agents_in_use) and cfg_data_i; ready is always high, write only when idle.
// Result: one item per input item, on the result ports for exactly one cycle
//   with done_o high. The receiver cannot stall, so nothing backs up.
// Writes answer in the next cycle, and busy stays low.
//   An assign with n agents in use runs up to three scans over the weight
//   memory (one read per cycle), a multiply and a round/add step for the
//   threshold, and, if any agent qualifies, a 16-step bit-serial remainder
//   of the draw by the qualifying count.
// One item at a time: busy is high from accept to the cycle before done_o.
// Reset: the task-taken memory is swept to zero, one entry per cycle;
//   busy is high meanwhile, config writes still land.
//   Weights and capacities hold garbage until written.
module rcl_random_agent_assign_core #(
  parameter int unsigned MAX_AGENTS  = rcl_raa_pkg::MAX_AGENTS_DEF,
  parameter int unsigned MAX_TASKS   = rcl_raa_pkg::MAX_TASKS_DEF,
  parameter int unsigned WEIGHT_BITS = rcl_raa_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rcl_raa_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rcl_raa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [rcl_raa_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [rcl_raa_pkg::AGENT_W-1:0]     agent_index_i,
  input  logic [rcl_raa_pkg::TASK_W-1:0]      task_index_i,
  input  logic [rcl_raa_pkg::LOAD_W-1:0]      load_value_i,
  input  logic [rcl_raa_pkg::DRAW_W-1:0]      rank_draw_i,
  output logic                                done_o,
  output logic [rcl_raa_pkg::STATUS_W-1:0]    status_o,
  output logic [rcl_raa_pkg::AGENT_W-1:0]     chosen_agent_o,
  output logic [rcl_raa_pkg::CAP_OUT_W-1:0]   capacity_left_o,
  output logic [rcl_raa_pkg::THR_OUT_W-1:0]   weight_threshold_o,
  output logic [rcl_raa_pkg::COUNT_W-1:0]     qualifying_count_o,
  output logic                                task_was_open_o
);

  import rcl_raa_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_AGENTS);
  localparam int unsigned CW     = $clog2(MAX_AGENTS + 1);
  localparam int unsigned TW     = $clog2(MAX_TASKS);
  localparam int unsigned WB     = WEIGHT_BITS;
  localparam int unsigned PW     = WB + GAMMA_W;
  localparam int unsigned SW     = PW + 1;
  // weight memory row = agent, column = task (task field padded to 2^TW)
  localparam int unsigned WDEPTH = MAX_AGENTS * (1 << TW);
  localparam logic [WB-1:0] WMAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MINMAX, S_MUL, S_ADD, S_COUNT, S_MOD, S_SELECT
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [AGENT_W-1:0]   agent;
    logic [CAP_OUT_W-1:0] cap;
    logic [THR_OUT_W-1:0] thr;
    logic [COUNT_W-1:0]   cnt;
    logic                 open;
  } res_t;

  function automatic res_t make_res(status_e st, logic [AW-1:0] ag, logic [WB-1:0] cap,
                                    logic [WB-1:0] thr, logic [CW-1:0] cnt, logic open);
    res_t r;
    r.status = st;
    r.agent  = AGENT_W'(ag);
    r.cap    = CAP_OUT_W'(cap);
    r.thr    = THR_OUT_W'(thr);
    r.cnt    = COUNT_W'(cnt);
    r.open   = open;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GAMMA_W-1:0]  gamma_q;
  logic [AGENTS_W-1:0] agents_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q  <= '0;
      agents_q <= AGENTS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAMMA:  gamma_q  <= cfg_data_i[GAMMA_W-1:0];
        CFG_AGENTS: agents_q <= cfg_data_i[AGENTS_W-1:0];
        default: ;
      endcase
    end
  end

  // agents in use clamped to 1..MAX_AGENTS
  logic [CW-1:0] n_eff;
  always_comb begin
    if (agents_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(agents_q) > MAX_AGENTS) begin
      n_eff = CW'(MAX_AGENTS);
    end else begin
      n_eff = CW'(agents_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  state_e        state_q;
  logic [TW-1:0] clr_q;
  logic [TW-1:0] task_q;
  logic [DRAW_W-1:0] draw_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] iss_q;     // next agent to read
  logic          ret_v_q;   // read data valid this cycle
  logic [AW-1:0] ret_a_q;   // agent of the returning read
  logic [WB-1:0] mn_q;
  logic [WB-1:0] mx_q;
  logic [PW-1:0] prod_q;
  logic [WB-1:0] thr_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] rank_q;
  logic          open_q;
  logic          done_q;
  res_t          res_q;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic             w_we;
  logic [AW+TW-1:0] w_waddr;
  logic [AW+TW-1:0] w_raddr;
  logic [WB-1:0]    w_wdata;
  logic [WB-1:0]    w_rdata;
  logic             c_we;
  logic [AW-1:0]    c_waddr;
  logic [AW-1:0]    c_raddr;
  logic [WB-1:0]    c_wdata;
  logic [WB-1:0]    c_rdata;
  logic             t_we;
  logic [TW-1:0]    t_waddr;
  logic             t_wdata;
  logic             t_rdata;

  rcl_raa_ram #(.WIDTH(WB), .DEPTH(WDEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  rcl_raa_ram #(.WIDTH(WB), .DEPTH(MAX_AGENTS)) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  rcl_raa_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_taken_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (task_q),
    .rdata_o (t_rdata)
  );

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic          accept;
  logic          agent_ok;
  logic          task_ok;
  logic [WB-1:0] load_w;
  logic          scanning;
  logic          issue;
  logic          scan_end;
  logic          hit;
  logic          pick;
  logic [WB-1:0] new_cap;
  logic [SW-1:0] thr_sum;
  logic [WB-1:0] thr_d;
  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_rem;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign agent_ok = 32'(agent_index_i) < MAX_AGENTS;
  assign task_ok  = 32'(task_index_i) < MAX_TASKS;
  assign load_w   = WB'(load_value_i);

  // One read per cycle over agents 0..n-1; data comes back in the next cycle.
  assign scanning = (state_q == S_MINMAX) || (state_q == S_COUNT) || (state_q == S_SELECT);
  assign issue    = scanning && (iss_q < n_q);
  assign scan_end = scanning && (iss_q == n_q) && !ret_v_q;
  assign w_raddr  = {iss_q[AW-1:0], task_q};
  assign c_raddr  = iss_q[AW-1:0];

  // agent qualifies: weight within threshold and within its capacity
  assign hit     = ret_v_q && (w_rdata <= thr_q) && (c_rdata >= w_rdata);
  assign pick    = (state_q == S_SELECT) && hit && (rank_q == '0);
  assign new_cap = c_rdata - w_rdata;

  // Stores only change on the reset sweep, on a write item or on the pick,
  // which is the last act of an assign; the next item's reads start after that
  // edge, so no read of the same item ever sees a pending write.
  assign w_we    = accept && (opcode_e'(opcode_i) == OP_WRITE_WEIGHT) && agent_ok && task_ok;
  assign w_waddr = {AW'(agent_index_i), TW'(task_index_i)};
  assign w_wdata = load_w;

  assign c_we    = (accept && (opcode_e'(opcode_i) == OP_WRITE_CAP) && agent_ok) || pick;
  assign c_waddr = pick ? ret_a_q : AW'(agent_index_i);
  assign c_wdata = pick ? new_cap : load_w;

  assign t_we    = (state_q == S_CLEAR) || pick;
  assign t_waddr = (state_q == S_CLEAR) ? clr_q : task_q;
  assign t_wdata = (state_q != S_CLEAR);

  // thr = min + ceil(gamma * spread / 256), saturated to the weight range
  always_comb begin
    thr_sum = SW'(mn_q) + ((SW'(prod_q) + SW'(ROUND_ADD)) >> FRAC_BITS);
    if (thr_sum > SW'(WMAX)) begin
      thr_d = WMAX;
    end else begin
      thr_d = thr_sum[WB-1:0];
    end
  end

  assign mod_start = (state_q == S_COUNT) && scan_end && (cnt_q != '0);

  rcl_raa_mod #(.DIVIDEND_W(DRAW_W), .DIVISOR_W(CW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (draw_q),
    .divisor_i  (cnt_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      task_q  <= '0;
      draw_q  <= '0;
      n_q     <= '0;
      iss_q   <= '0;
      ret_v_q <= 1'b0;
      ret_a_q <= '0;
      mn_q    <= '0;
      mx_q    <= '0;
      prod_q  <= '0;
      thr_q   <= '0;
      cnt_q   <= '0;
      rank_q  <= '0;
      open_q  <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q  <= 1'b0;
      ret_v_q <= issue;
      ret_a_q <= iss_q[AW-1:0];
      if (issue) begin
        iss_q <= iss_q + 1'b1;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == TW'(MAX_TASKS - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            task_q <= TW'(task_index_i);
            draw_q <= rank_draw_i;
            n_q    <= n_eff;
            iss_q  <= '0;
            unique case (opcode_e'(opcode_i))
              OP_ASSIGN: begin
                if (task_ok) begin
                  mn_q    <= WMAX;
                  mx_q    <= '0;
                  state_q <= S_MINMAX;
                end else begin
                  res_q  <= make_res(ST_NO_AGENT, '0, '0, '0, '0, 1'b0);
                  done_q <= 1'b1;
                end
              end
              OP_WRITE_WEIGHT, OP_WRITE_CAP, OP_NOP: begin
                res_q  <= make_res(ST_WRITE_OK, '0, '0, '0, '0, 1'b0);
                done_q <= 1'b1;
              end
            endcase
          end
        end

        S_MINMAX: begin
          if (ret_v_q) begin
            if (w_rdata < mn_q) begin
              mn_q <= w_rdata;
            end
            if (w_rdata > mx_q) begin
              mx_q <= w_rdata;
            end
          end
          if (scan_end) begin
            open_q  <= !t_rdata;
            state_q <= S_MUL;
          end
        end

        S_MUL: begin
          prod_q  <= PW'(gamma_q) * PW'(mx_q - mn_q);
          state_q <= S_ADD;
        end

        S_ADD: begin
          thr_q   <= thr_d;
          cnt_q   <= '0;
          iss_q   <= '0;
          state_q <= S_COUNT;
        end

        S_COUNT: begin
          if (hit) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (scan_end) begin
            if (cnt_q == '0) begin
              res_q   <= make_res(ST_NO_AGENT, '0, '0, thr_q, '0, open_q);
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_MOD;
            end
          end
        end

        S_MOD: begin
          if (mod_done) begin
            rank_q  <= mod_rem;
            iss_q   <= '0;
            state_q <= S_SELECT;
          end
        end

        S_SELECT: begin
          if (pick) begin
            res_q   <= make_res(ST_ASSIGNED, ret_a_q, new_cap, thr_q, cnt_q, open_q);
            done_q  <= 1'b1;
            ret_v_q <= 1'b0;
            state_q <= S_IDLE;
          end else if (hit) begin
            rank_q <= rank_q - 1'b1;
          end else if (scan_end) begin
            // rank always lands inside the count; kept for safety
            res_q   <= make_res(ST_NO_AGENT, '0, '0, thr_q, cnt_q, open_q);
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign done_o             = done_q;
  assign status_o           = res_q.status;
  assign chosen_agent_o     = res_q.agent;
  assign capacity_left_o    = res_q.cap;
  assign weight_threshold_o = res_q.thr;
  assign qualifying_count_o = res_q.cnt;
  assign task_was_open_o    = res_q.open;

endmodule

[design/rcl_raa_checker.sv]
`include "rcl_random_agent_assign_core_defines.svh"

module rcl_raa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [rcl_raa_pkg::OPCODE_W-1:0]  opcode_i,
  input logic                              done_o,
  input logic [rcl_raa_pkg::STATUS_W-1:0]  status_o,
  input logic [rcl_raa_pkg::AGENT_W-1:0]   chosen_agent_o,
  input logic [rcl_raa_pkg::CAP_OUT_W-1:0] capacity_left_o,
  input logic [rcl_raa_pkg::COUNT_W-1:0]   qualifying_count_o
);

  import rcl_raa_pkg::*;

  // a result only comes out once the item is finished
  `RCL_ASSERT_NOW(a_done_not_busy, clk_i, rst_ni, done_o, !busy, "result while busy")

  // non-assign items are answered in the next cycle as writes
  `RCL_ASSERT_NEXT(a_write_answer, clk_i, rst_ni, start && !busy && opcode_i != OP_ASSIGN, done_o && status_o == ST_WRITE_OK, "write item not answered")

  // an assignment implies at least one candidate
  `RCL_ASSERT_NOW(a_assign_count, clk_i, rst_ni, done_o && status_o == ST_ASSIGNED, qualifying_count_o != '0, "assigned with empty list")

  // a miss reports no agent and no capacity
  `RCL_ASSERT_NOW(a_miss_clean, clk_i, rst_ni, done_o && status_o == ST_NO_AGENT, chosen_agent_o == '0 && capacity_left_o == '0, "miss with agent fields set")

endmodule

bind rcl_random_agent_assign_core rcl_raa_checker u_raa_checker (.*);
